// File: rtl/tgarle_pkg.sv
package tgarle_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [1:0] FMT_GREY = 2'd0;
  localparam logic [1:0] FMT_555  = 2'd1;
  localparam logic [1:0] FMT_BGR  = 2'd2;
  localparam logic [1:0] FMT_BGRA = 2'd3;

  localparam logic REG_PIXEL_FORMAT = 1'b0;
  localparam logic REG_RLE_ENABLE   = 1'b1;

  localparam logic [7:0] RUN_FLAG   = 8'h80;
  localparam logic [7:0] RUN_BIAS   = 8'd127;

  typedef struct packed {
    logic [1:0] pixel_format;
    logic       rle_enable;
    logic       clear;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] palette_index;
    logic [7:0]  repeat_count;
  } pixel_t;

endpackage

// File: rtl/tga_rle_pixel_decoder_unit.sv
// targa pixel stream decoder, one byte per transaction
// input channel: data_byte with in_valid / in_stall; a byte is taken at a
//   rising edge with in_valid high and in_stall low
// output channel: red, green, blue, alpha, palette_index, repeat_count with
//   out_valid / out_stall; one transaction per decoded pixel, a run gives a
//   single transaction carrying its repeat count
// config: apb registers pixel_format at 0x0 and rle_enable at 0x4; any write
//   drops a partial pixel or open packet
// throughput: one byte per cycle while in_stall is low; 1 to 4 bytes per pixel
//   plus one header byte per packet in rle mode
// output: a pixel is registered into the result or skid stage
// stall: a result register and a one-entry skid stage sit on the output;
//   in_stall rises only once both hold a waiting pixel
// reset: synchronous, clears decode state, output valid, and sets
//   pixel_format to 24-bit bgr with rle off
module tga_rle_pixel_decoder_unit
  import tgarle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic [7:0]        alpha,
  output logic [15:0]       palette_index,
  output logic [7:0]        repeat_count
);

  cfg_t   cfg;
  logic   in_fire;
  logic   res_valid;
  pixel_t res;
  pixel_t out_data;
  logic   full;

  assign in_stall = full;
  assign in_fire  = in_valid && !full;

  tgarle_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tgarle_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  tgarle_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

  assign red           = out_data.red;
  assign green         = out_data.green;
  assign blue          = out_data.blue;
  assign alpha         = out_data.alpha;
  assign palette_index = out_data.palette_index;
  assign repeat_count  = out_data.repeat_count;

endmodule

// File: rtl/tgarle_regs.sv
module tgarle_regs
  import tgarle_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic [1:0] pixel_format;
  logic       rle_enable;
  logic       wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_BGR;
      rle_enable   <= 1'b0;
    end else if (wr) begin
      case (paddr[2])
        REG_PIXEL_FORMAT: pixel_format <= pwdata[1:0];
        REG_RLE_ENABLE:   rle_enable   <= pwdata[0];
        default:          rle_enable   <= rle_enable;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PIXEL_FORMAT: prdata = {{(DATA_W-2){1'b0}}, pixel_format};
      REG_RLE_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, rle_enable};
      default:          prdata = '0;
    endcase
  end

  assign cfg.pixel_format = pixel_format;
  assign cfg.rle_enable   = rle_enable;
  assign cfg.clear        = wr;

endmodule

// File: rtl/tgarle_core.sv
module tgarle_core
  import tgarle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output pixel_t     res
);

  logic [6:0]  raw_remaining, raw_remaining_next;
  logic        run_active, run_active_next;
  logic [7:0]  run_length, run_length_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic        header_taken, header_taken_next;
  logic [23:0] partial_pixel, partial_pixel_next;
  logic [7:0]  b0, b1, b2;

  assign b0 = partial_pixel[7:0];
  assign b1 = partial_pixel[15:8];
  assign b2 = partial_pixel[23:16];

  always_comb begin
    raw_remaining_next = raw_remaining;
    run_active_next    = run_active;
    run_length_next    = run_length;
    byte_phase_next    = byte_phase;
    header_taken_next  = header_taken;
    partial_pixel_next = partial_pixel;
    res_valid          = 1'b0;
    res                = '0;

    if (in_fire) begin
      if (cfg.rle_enable && !header_taken) begin
        if ((data_byte & RUN_FLAG) != 8'd0) begin
          run_active_next    = 1'b1;
          run_length_next    = data_byte - RUN_BIAS;
          raw_remaining_next = '0;
        end else begin
          run_active_next    = 1'b0;
          run_length_next    = '0;
          raw_remaining_next = data_byte[6:0];
        end
        header_taken_next  = 1'b1;
        byte_phase_next    = '0;
        partial_pixel_next = '0;
      end else if (byte_phase < cfg.pixel_format) begin
        partial_pixel_next = partial_pixel | (24'(data_byte) << {byte_phase, 3'b000});
        byte_phase_next    = byte_phase + 2'd1;
      end else begin
        res_valid = 1'b1;
        case (cfg.pixel_format)
          FMT_GREY: begin
            res.red           = data_byte;
            res.green         = data_byte;
            res.blue          = data_byte;
            res.palette_index = {8'd0, data_byte};
          end
          FMT_555: begin
            res.red           = {3'd0, data_byte[6:2]};
            res.green         = {3'd0, data_byte[1:0], b0[7:5]};
            res.blue          = {3'd0, b0[4:0]};
            res.palette_index = {data_byte, b0};
          end
          FMT_BGR: begin
            res.blue  = b0;
            res.green = b1;
            res.red   = data_byte;
          end
          default: begin
            res.blue  = b0;
            res.green = b1;
            res.red   = b2;
            res.alpha = data_byte;
          end
        endcase
        byte_phase_next    = '0;
        partial_pixel_next = '0;
        res.repeat_count   = 8'd1;
        if (cfg.rle_enable) begin
          if (run_active) begin
            res.repeat_count  = run_length;
            run_active_next   = 1'b0;
            run_length_next   = '0;
            header_taken_next = 1'b0;
          end else if (raw_remaining == 7'd0) begin
            header_taken_next = 1'b0;
          end else begin
            raw_remaining_next = raw_remaining - 7'd1;
          end
        end
      end
    end

    if (cfg.clear) begin
      raw_remaining_next = '0;
      run_active_next    = 1'b0;
      run_length_next    = '0;
      byte_phase_next    = '0;
      header_taken_next  = 1'b0;
      partial_pixel_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_remaining <= '0;
      run_active    <= 1'b0;
      run_length    <= '0;
      byte_phase    <= '0;
      header_taken  <= 1'b0;
      partial_pixel <= '0;
    end else begin
      raw_remaining <= raw_remaining_next;
      run_active    <= run_active_next;
      run_length    <= run_length_next;
      byte_phase    <= byte_phase_next;
      header_taken  <= header_taken_next;
      partial_pixel <= partial_pixel_next;
    end
  end

endmodule

// File: rtl/tgarle_outq.sv
module tgarle_outq
  import tgarle_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  pixel_t push_data,
  input  logic   out_stall,
  output logic   out_valid,
  output pixel_t out_data,
  output logic   full
);

  logic   skid_valid;
  pixel_t skid_data;
  logic   pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// File: rtl/tgarle_checker.sv
module tgarle_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [7:0]  alpha,
  input logic [15:0] palette_index,
  input logic [7:0]  repeat_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) &&
      $stable(blue) && $stable(alpha) && $stable(palette_index) &&
      $stable(repeat_count))
    else $error("stalled output transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall raised without output backpressure");

  a_repeat_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != 8'd0)
    else $error("zero repeat count");

endmodule

bind tga_rle_pixel_decoder_unit tgarle_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .red           (red),
  .green         (green),
  .blue          (blue),
  .alpha         (alpha),
  .palette_index (palette_index),
  .repeat_count  (repeat_count)
);
